### design/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  BLANK_CODE   = 8'h20;
    localparam logic [15:0] CLEAR_CELL   = 16'h0720;
    localparam int          BG_SHIFT     = 12;
    localparam int          FG_SHIFT     = 8;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [3:0]  fg_colour;
        logic [3:0]  bg_colour;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic put;
        logic newline;
        logic scroll_start;
        logic scroll_step;
        logic fill_step;
        logic clear_start;
        logic clear_step;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic is_put_char;
        logic is_newline;
        logic is_clear;
        logic at_last_row;
        logic copy_last;
        logic cnt_last;
    } t_status;

    function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [3:0] fg,
                                              input logic [3:0] bg);
        make_cell = (16'(bg) << BG_SHIFT) | (16'(fg) << FG_SHIFT) | 16'(ch);
    endfunction

endpackage

`default_nettype wire

### design/tccw_if.sv
`default_nettype none

interface tccw_in_if;
    import tccw_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tccw_out_if;
    import tccw_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### design/tccw_datapath.sv
`default_nettype none

module tccw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tccw_pkg::t_in_item  i_item,
    input  wire tccw_pkg::t_cmd      i_cmd,
    output tccw_pkg::t_status        o_status,
    output tccw_pkg::t_out_item      o_result
);
    import tccw_pkg::*;

    localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
    localparam int unsigned COPY_LAST  = COLUMNS * (ROWS - 1) - 1;
    localparam int          AW         = $clog2(CELL_COUNT);
    localparam int          COL_W      = $clog2(COLUMNS);
    localparam int          ROW_W      = $clog2(ROWS);

    logic [15:0]      mem [CELL_COUNT];

    t_in_item         r_item;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic             r_wr_en, n_wr_en;
    logic             r_wr_from_mem;
    logic [AW-1:0]    r_wr_addr, n_wr_addr;
    logic [15:0]      r_wr_data, n_wr_data;
    logic [15:0]      r_rd_data;
    t_out_item        r_result;

    logic             col_last;
    logic             row_last;
    logic             idx_ok;
    logic [AW-1:0]    put_addr;
    logic [AW-1:0]    rd_addr;
    logic [15:0]      wr_data;

    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign idx_ok   = (32'(r_item.cell_index) < CELL_COUNT);
    assign put_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign rd_addr  = i_cmd.scroll_step ? r_cnt + AW'(COLUMNS) : AW'(r_item.cell_index);
    assign wr_data  = r_wr_from_mem ? r_rd_data : r_wr_data;

    always_comb begin
        o_status.is_put_char = 1'b0;
        o_status.is_newline  = 1'b0;
        o_status.is_clear    = 1'b0;
        case (r_item.operation)
            OP_PUT: begin
                o_status.is_put_char = (r_item.char_code != NEWLINE_CODE);
                o_status.is_newline  = (r_item.char_code == NEWLINE_CODE);
            end
            OP_CLEAR: o_status.is_clear = 1'b1;
            default: ;
        endcase
        o_status.at_last_row = row_last;
        o_status.copy_last   = (r_cnt == AW'(COPY_LAST));
        o_status.cnt_last    = (r_cnt == AW'(CELL_COUNT - 1));
    end

    // cursor and sweep counter
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_cnt = r_cnt;
        if (i_cmd.put) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
        if (i_cmd.newline) begin
            n_col = '0;
            n_row = row_last ? r_row : r_row + ROW_W'(1);
        end
        if (i_cmd.clear_start) begin
            n_col = '0;
            n_row = '0;
        end
        if (i_cmd.clear_start || i_cmd.scroll_start) begin
            n_cnt = '0;
        end else if (i_cmd.clear_step || i_cmd.scroll_step || i_cmd.fill_step) begin
            n_cnt = r_cnt + AW'(1);
        end
    end

    // one write a cycle, registered so that a scroll copy meets its read data
    always_comb begin
        n_wr_en   = i_cmd.put || i_cmd.clear_step || i_cmd.scroll_step || i_cmd.fill_step;
        n_wr_addr = i_cmd.put ? put_addr : r_cnt;
        if (i_cmd.put) begin
            n_wr_data = make_cell(r_item.char_code, r_item.fg_colour, r_item.bg_colour);
        end else if (i_cmd.fill_step) begin
            n_wr_data = make_cell(BLANK_CODE, r_item.fg_colour, r_item.bg_colour);
        end else begin
            n_wr_data = CLEAR_CELL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_wr_en <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            r_wr_en <= n_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr     <= n_wr_addr;
        r_wr_data     <= n_wr_data;
        r_wr_from_mem <= i_cmd.scroll_step;
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.load_result) begin
            r_result.cell_data  <= (r_item.operation == OP_READ && idx_ok) ? r_rd_data : '0;
            r_result.cursor_col <= 7'(r_col);
            r_result.cursor_row <= 5'(r_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            mem[r_wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

### design/tccw_ctrl.sv
`default_nettype none

module tccw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire tccw_pkg::t_status i_status,
    output tccw_pkg::t_cmd         o_cmd
);
    import tccw_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_CLEAR  = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_had_item, n_had_item;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_had_item = r_had_item;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_had_item  = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_put_char) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_DONE;
                end else if (i_status.is_newline) begin
                    o_cmd.newline = 1'b1;
                    if (i_status.at_last_row) begin
                        o_cmd.scroll_start = 1'b1;
                        n_state            = S_SCROLL;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_status.is_clear) begin
                    o_cmd.clear_start = 1'b1;
                    n_state           = S_CLEAR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                // the sweep after reset has no item to answer
                if (i_status.cnt_last) begin
                    n_state = r_had_item ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_had_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_had_item  <= n_had_item;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### design/text_console_cell_writer_core.sv
`default_nettype none

// Text console cell writer: a COLUMNS x ROWS buffer of 16-bit cells (bg, fg, char) in one
// on-chip memory with one write and one registered read a cycle, plus a cursor. After reset
// the block sweeps the buffer to light-grey blanks and accepts no item until that sweep
// ends. A put, a newline that stays on screen, a read or an unused code passes through the
// states EXEC and DONE; in DONE its result is registered once the output is free or taken,
// and the next item can be taken back in IDLE. A clear sweeps the buffer, and a newline on
// the last row scrolls it by copying COLUMNS*(ROWS-1) cells and blanking the last row; the
// single memory write port paces both sweeps, which end in DONE. One item is worked on at a
// time; the result register lets the next item in while a result waits.
module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tccw_in_if.sink     i_in,
    tccw_out_if.source  o_out
);
    import tccw_pkg::*;

    t_cmd      cmd;
    t_status   status;
    t_out_item result;
    logic      out_valid;
    logic      in_ready;

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tccw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (result)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.item  = result;

endmodule

`default_nettype wire
